### hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by the cache top level and its port checker; no dependencies.
package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    // Bit positions of the result flags in the master-side tuser.
    localparam int FOUND_BIT   = 0;
    localparam int EVICTED_BIT = 1;
    localparam int OUT_USER_W  = 2;

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [VALUE_W-1:0] write_value;
        logic [KEY_W-1:0]   key;
        op_t                op;
    } request_t;

endpackage

### hw/rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg for field widths, the request type and flag positions.

// The cache takes one get or put request per clock cycle while the output is not
// stalled and returns one result per request, in order; the request and then its
// result are registered. Every slot compares its key with the request in the same
// cycle, and the recency ranks of all slots are updated in that cycle, so the rate
// is one request per cycle when not stalled, set by that single compare-and-update step.
// Slot contents need no clearing after reset; only valid marks and ranks are cleared.
// The capacity register may be written only while no request is in flight; a
// value of 0 acts as 1 and a value above ENTRIES acts as ENTRIES.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data,        // capacity_in_use

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,    // key [31:0], write_value [63:32]
    input  logic [0:0]          s_axis_tuser,    // op

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [VALUE_W-1:0]  m_axis_tdata,    // read_value [31:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser   // found [0], evicted [1]
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;

    logic [CAP_W-1:0]   cap_reg;
    logic               in_valid_reg;
    request_t           req_reg;
    logic               out_valid_reg;
    logic               found_reg;
    logic               evicted_reg;
    logic [VALUE_W-1:0] read_value_reg;

    logic               valid_reg [ENTRIES];
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    logic [VALUE_W-1:0] value_reg [ENTRIES];
    logic [CNT_W-1:0]   filled_reg;

    logic               valid_next [ENTRIES];
    logic [RANK_W-1:0]  rank_next  [ENTRIES];
    logic [KEY_W-1:0]   key_next   [ENTRIES];
    logic [VALUE_W-1:0] value_next [ENTRIES];
    logic [CNT_W-1:0]   filled_next;
    logic               out_valid_next;
    logic               in_valid_next;
    logic               found_next;
    logic               evicted_next;
    logic [VALUE_W-1:0] read_value_next;

    logic               s_accept;
    logic               fire;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [IDX_W-1:0]   target_idx;
    logic [RANK_W-1:0]  victim_rank;
    logic [RANK_W-1:0]  hit_rank;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               full;

    assign cfg_ready     = 1'b1;
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid              = out_valid_reg;
    assign m_axis_tdata               = read_value_reg;
    assign m_axis_tuser[FOUND_BIT]    = found_reg;
    assign m_axis_tuser[EVICTED_BIT]  = evicted_reg;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full        = CMP_W'(filled_reg) >= eff_cap;
        victim_rank = RANK_W'(filled_reg - CNT_W'(1));

        hit_any    = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == req_reg.key)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == victim_rank)
            begin
                victim_idx = IDX_W'(i);
            end
        end
        hit_rank   = rank_reg[hit_idx];
        target_idx = full ? victim_idx : free_idx;
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
        end
        filled_next     = filled_reg;
        found_next      = found_reg;
        evicted_next    = evicted_reg;
        read_value_next = read_value_reg;

        if (fire)
        begin
            found_next      = hit_any;
            evicted_next    = 1'b0;
            read_value_next = '0;
            if (hit_any)
            begin
                if (req_reg.op == OP_GET)
                begin
                    read_value_next = value_reg[hit_idx];
                end
                else
                begin
                    value_next[hit_idx] = req_reg.write_value;
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == hit_idx)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && rank_reg[i] < hit_rank)
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end
            else if (req_reg.op == OP_GET)
            begin
                read_value_next = MISS_VALUE;
            end
            else
            begin
                evicted_next = full;
                if (!full)
                begin
                    filled_next = filled_reg + CNT_W'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == target_idx)
                    begin
                        valid_next[i] = 1'b1;
                        key_next[i]   = req_reg.key;
                        value_next[i] = req_reg.write_value;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end

        out_valid_next = fire || (out_valid_reg && !m_axis_tready);
        in_valid_next  = s_accept || (in_valid_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filled_reg    <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            filled_reg    <= filled_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            req_reg.op          <= op_t'(s_axis_tuser[0]);
            req_reg.key         <= s_axis_tdata[KEY_W-1:0];
            req_reg.write_value <= s_axis_tdata[KEY_W +: VALUE_W];
        end
        found_reg      <= found_next;
        evicted_reg    <= evicted_next;
        read_value_reg <= read_value_next;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
        end
    end

endmodule

### hw/rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg for widths and result flag positions.
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [VALUE_W-1:0]    m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // An eviction only happens on a put miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[FOUND_BIT] && m_axis_tuser[EVICTED_BIT]))
    else $error("Result beat reports both a hit and an eviction.");

    // An eviction result, which is always a put, carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[EVICTED_BIT]) |-> (m_axis_tdata == '0))
    else $error("Eviction beat carries a nonzero value.");

    // A miss carries either the miss marker of a get or the zero of a put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[FOUND_BIT])
            |-> (m_axis_tdata == '0 || m_axis_tdata == MISS_VALUE))
    else $error("Miss beat carries an unexpected value.");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("Stalled result beat changed or dropped.");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

### bench/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: directed table, then random phases.
// Depends on lkvc_pkg and the cache RTL; carries its own recency-rank model of the store.
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed
    {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
    } cache_result_t;

    typedef enum logic
    {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t          kind;
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] data;
        logic               typed;
        cache_result_t      want;
    } plan_row_t;

    localparam cache_result_t GET_MISS = '{1'b0, MISS_VALUE, 1'b0};
    localparam cache_result_t PUT_NEW  = '{1'b0, 32'h0, 1'b0};
    localparam cache_result_t PUT_HIT  = '{1'b1, 32'h0, 1'b0};
    localparam cache_result_t MODELED  = '{1'b0, 32'h0, 1'b0};

    localparam int PLAN_ROWS = 23;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;   // key [31:0], write_value [63:32]
    logic [0:0]            s_axis_tuser = '0;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]    m_axis_tdata;        // read_value [31:0]
    logic [OUT_USER_W-1:0] m_axis_tuser;        // found [0], evicted [1]

    logic                  slot_used [SLOTS];
    logic [KEY_W-1:0]      slot_tag [SLOTS];
    logic [VALUE_W-1:0]    slot_data [SLOTS];
    int unsigned           slot_age [SLOTS];
    int unsigned           fill_count;
    logic [CAP_W-1:0]      capacity_reg;

    cache_result_t         pending_results [$];
    plan_row_t             plan [PLAN_ROWS];
    logic [KEY_W-1:0]      key_pool [24];
    int                    pool_size;
    bit                    quiet_phase;
    int                    mismatch_count;
    int                    request_count;
    int                    hit_count;
    int                    eviction_count;
    int                    setting_count;

    lru_key_value_cache #(.ENTRIES(SLOTS)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("[lru_key_value_cache] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (quiet_phase)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Slot s becomes most recent; every valid slot younger than limit ages by one.
    function automatic void make_most_recent(int s, int unsigned limit);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i != s && slot_used[i] && slot_age[i] < limit)
            begin
                slot_age[i]++;
            end
        end
        slot_age[s] = 0;
    endfunction

    function automatic cache_result_t cache_access(op_t op, logic [KEY_W-1:0] key,
                                                   logic [VALUE_W-1:0] data);
        cache_result_t res;
        int            hit;
        int            victim;
        int unsigned   cap;
        int unsigned   oldest;
        res = '{1'b0, '0, 1'b0};
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_tag[i] == key)
            begin
                hit = i;
            end
        end
        if (hit >= 0)
        begin
            res.found = 1'b1;
            if (op == OP_GET)
            begin
                res.read_value = slot_data[hit];
            end
            else
            begin
                slot_data[hit] = data;
            end
            make_most_recent(hit, slot_age[hit]);
        end
        else if (op == OP_GET)
        begin
            res.read_value = MISS_VALUE;
        end
        else
        begin
            cap = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
            victim = -1;
            if (fill_count < cap)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (victim < 0 && !slot_used[i])
                    begin
                        victim = i;
                    end
                end
            end
            if (victim >= 0)
            begin
                fill_count++;
            end
            else
            begin
                oldest = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i] && (victim < 0 || slot_age[i] > oldest))
                    begin
                        victim = i;
                        oldest = slot_age[i];
                    end
                end
                if (victim >= 0)
                begin
                    res.evicted = 1'b1;
                end
                else
                begin
                    victim = 0;
                end
            end
            slot_used[victim] = 1'b1;
            slot_tag[victim]  = key;
            slot_data[victim] = data;
            slot_age[victim]  = SLOTS;
            make_most_recent(victim, SLOTS);
        end
        return res;
    endfunction

    task automatic issue_request(input op_t op, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] data, input logic typed,
                                 input cache_result_t want);
        int            gap;
        cache_result_t model;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, key};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        model = cache_access(op, key, data);
        pending_results.push_back(typed ? want : model);
        request_count++;
        hit_count      += model.found;
        eviction_count += model.evicted;
    endtask

    // The capacity may change only with nothing in flight.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid    <= 1'b0;
        capacity_reg  = cap;
        setting_count++;
    endtask

    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        cache_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[FOUND_BIT] !== want.found)
                begin
                    $error("found: expected %b, got %b", want.found, m_axis_tuser[FOUND_BIT]);
                    mismatch_count++;
                end
                if (m_axis_tdata !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[EVICTED_BIT] !== want.evicted)
                begin
                    $error("evicted: expected %b, got %b", want.evicted,
                           m_axis_tuser[EVICTED_BIT]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps [7];
        op_t              op;
        logic [KEY_W-1:0] key;

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_data[i] = '0;
            slot_age[i]  = 0;
        end
        fill_count     = 0;
        capacity_reg   = CAP_RESET;
        quiet_phase    = 1'b0;
        mismatch_count = 0;
        request_count  = 0;
        hit_count      = 0;
        eviction_count = 0;
        setting_count  = 0;

        plan = '{
            '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, GET_MISS},
            '{ROW_REQ, OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, GET_MISS},
            '{ROW_REQ, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, PUT_NEW},
            '{ROW_REQ, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, PUT_NEW},
            '{ROW_REQ, OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, PUT_NEW},
            '{ROW_REQ, OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, PUT_NEW},
            '{ROW_REQ, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
              '{1'b1, 32'h7FFF_FFFF, 1'b0}},
            '{ROW_REQ, OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{1'b1, 32'h8000_0000, 1'b0}},
            '{ROW_REQ, OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1, PUT_HIT},
            '{ROW_REQ, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{1'b1, 32'h1234_5678, 1'b0}},
            '{ROW_REQ, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{1'b1, 32'hFFFF_FFFF, 1'b0}},
            '{ROW_CFG, OP_GET, 32'h0, 32'd2, 1'b0, MODELED},
            '{ROW_REQ, OP_PUT, 32'h0000_0005, 32'hA5A5_A5A5, 1'b0, MODELED},
            '{ROW_REQ, OP_PUT, 32'h0000_0006, 32'h5A5A_5A5A, 1'b0, MODELED},
            '{ROW_REQ, OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, MODELED},
            '{ROW_REQ, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, MODELED},
            '{ROW_CFG, OP_GET, 32'h0, 32'd0, 1'b0, MODELED},
            '{ROW_REQ, OP_PUT, 32'h0000_0007, 32'h0000_0007, 1'b0, MODELED},
            '{ROW_REQ, OP_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, MODELED},
            '{ROW_CFG, OP_GET, 32'h0, 32'd31, 1'b0, MODELED},
            '{ROW_REQ, OP_PUT, 32'h0000_0008, 32'h0000_0008, 1'b0, MODELED},
            '{ROW_REQ, OP_GET, 32'h0000_0008, 32'h0000_0000, 1'b0, MODELED},
            '{ROW_REQ, OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, MODELED}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                write_capacity(plan[r].data[CAP_W-1:0]);
            end
            else
            begin
                issue_request(plan[r].op, plan[r].key, plan[r].data, plan[r].typed,
                              plan[r].want);
            end
        end

        phase_caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'($urandom_range(0, 31)),
                       5'($urandom_range(2, 15))};
        for (int p = 0; p < 7; p++)
        begin
            write_capacity(phase_caps[p]);
            quiet_phase = (p == 2);
            pool_size = $urandom_range(2, 24);
            for (int k = 0; k < pool_size; k++)
            begin
                key_pool[k] = $urandom;
            end
            for (int n = 0; n < 55; n++)
            begin
                op  = op_t'($urandom_range(0, 1));
                key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_size - 1)]
                                                   : $urandom;
                issue_request(op, key, $urandom, 1'b0, MODELED);
            end
        end
        quiet_phase = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d requests (%0d hits, %0d evictions) under %0d capacity settings.",
                 request_count, hit_count, eviction_count, setting_count);
        $display("Capacity settings included 0, 1, 16, 31 and a cut below the current fill.");
        if (mismatch_count == 0)
        begin
            $display("[lru_key_value_cache] OK");
        end
        else
        begin
            $display("[lru_key_value_cache] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lru_key_value_cache.sv
hw/rtl/lkvc_checker.sv
bench/tb_lru_key_value_cache.sv
